### hdl/rtccs_pkg.sv
// Package for the RTC calendar setting stepper: command and write codes,
// reset constants and BCD helper functions. No dependencies.
`timescale 1ns / 1ps

package rtccs_pkg;

   localparam int unsigned YearWidth = 12;

   localparam logic [YearWidth-1:0] YEAR_FLOOR_RESET   = 12'd2015;
   localparam logic [YearWidth-1:0] YEAR_CEILING_RESET = 12'd2100;

   localparam logic [5:0] HOUR_LAST   = 6'd23;
   localparam logic [7:0] MINUTE_LAST = 8'd59;
   localparam logic [4:0] MONTH_LAST  = 5'd12;

   typedef enum logic [2:0] {
      CMD_LOAD       = 3'd0,
      CMD_ADD_HOUR   = 3'd1,
      CMD_ADD_MINUTE = 3'd2,
      CMD_ADD_YEAR   = 3'd3,
      CMD_ADD_MONTH  = 3'd4,
      CMD_ADD_DAY    = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      WR_NONE = 2'd0,
      WR_TIME = 2'd1,
      WR_DATE = 2'd2,
      WR_YEAR = 2'd3
   } write_kind_type;

   typedef enum logic [0:0] {
      CSR_YEAR_FLOOR   = 1'b0,
      CSR_YEAR_CEILING = 1'b1
   } csr_index_type;

   // high nibble * 10 + low nibble; digits above 9 taken as they are
   function automatic logic [7:0] from_bcd(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
   endfunction

   // divide by 10 through reciprocal multiply, exact for every 8-bit input
   function automatic logic [7:0] to_bcd(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  quot;
      logic [7:0]  quot10;
      logic [7:0]  rem;
      prod   = {8'd0, v} * 16'd205;
      quot   = prod[15:11];
      quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
      rem    = v - quot10;
      return {quot[3:0], rem[3:0]};
   endfunction

   function automatic logic [5:0] month_length(input logic [4:0] m, input logic [1:0] y);
      logic [5:0] len;
      if (m inside {5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12}) begin
         len = 6'd31;
      end else if (m inside {5'd4, 5'd6, 5'd9, 5'd11}) begin
         len = 6'd30;
      end else if (m == 5'd2) begin
         len = (y == 2'd0) ? 6'd29 : 6'd28;
      end else begin
         len = 6'd0;
      end
      return len;
   endfunction

endpackage

### hdl/rtc_calendar_setting_stepper.sv
// RTC calendar setting stepper, top level. Uses rtccs_pkg.
// A request passes the input register, then the result register, on its way from
// acceptance to the earliest response acceptance.
// Throughput: one transaction per cycle while rsp_ready is high; single-pass update.
// Reset (synchronous, active high): state cleared to zero, year floor/ceiling to 2015/2100,
// both stages empty.
`timescale 1ns / 1ps

module rtc_calendar_setting_stepper
   import rtccs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [11:0] csr_write_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_reg_seconds,
   input  logic [7:0]  req_reg_minutes,
   input  logic [7:0]  req_reg_hours,
   input  logic [7:0]  req_reg_day_year,
   input  logic [7:0]  req_reg_month_weekday,
   input  logic [15:0] req_ram_year,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_hours,
   output logic [7:0]  rsp_minutes,
   output logic [7:0]  rsp_seconds,
   output logic [5:0]  rsp_day_of_month,
   output logic [4:0]  rsp_month_number,
   output logic [11:0] rsp_year_value,
   output logic [2:0]  rsp_weekday,
   output logic [1:0]  rsp_write_kind,
   output logic [7:0]  rsp_write_byte0,
   output logic [7:0]  rsp_write_byte1,
   output logic [7:0]  rsp_write_byte2
);

   logic [11:0] year_floor_ff;
   logic [11:0] year_ceiling_ff;

   logic        in_valid_ff;
   logic [2:0]  cmd_ff;
   logic [7:0]  sec_reg_ff;
   logic [7:0]  min_reg_ff;
   logic [7:0]  hour_reg_ff;
   logic [7:0]  day_year_reg_ff;
   logic [7:0]  month_wd_reg_ff;
   logic [15:0] ram_year_ff;

   logic [5:0]  hour_ff,    hour_in;
   logic [7:0]  minute_ff,  minute_in;
   logic [7:0]  second_ff,  second_in;
   logic [5:0]  day_ff,     day_in;
   logic [4:0]  month_ff,   month_in;
   logic [11:0] year_ff,    year_in;
   logic [2:0]  weekday_ff, weekday_in;

   logic           out_valid_ff;
   write_kind_type kind_ff, kind_in;
   logic [7:0]     byte0_ff, byte0_in;
   logic [7:0]     byte1_ff, byte1_in;
   logic [7:0]     byte2_ff, byte2_in;

   logic advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         year_floor_ff   <= YEAR_FLOOR_RESET;
         year_ceiling_ff <= YEAR_CEILING_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_YEAR_FLOOR:   year_floor_ff   <= csr_write_data;
            CSR_YEAR_CEILING: year_ceiling_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff          <= req_command;
         sec_reg_ff      <= req_reg_seconds;
         min_reg_ff      <= req_reg_minutes;
         hour_reg_ff     <= req_reg_hours;
         day_year_reg_ff <= req_reg_day_year;
         month_wd_reg_ff <= req_reg_month_weekday;
         ram_year_ff     <= req_ram_year;
      end
   end

   // single-pass update of the calendar state for the registered transaction
   always_comb begin
      logic [11:0] y_sel;
      logic [1:0]  diff;
      logic        date_write;
      logic [7:0]  hour_dec;
      logic [7:0]  day_dec;
      logic [7:0]  month_dec;

      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      day_in     = day_ff;
      month_in   = month_ff;
      year_in    = year_ff;
      weekday_in = weekday_ff;
      kind_in    = WR_NONE;
      byte0_in   = 8'd0;
      byte1_in   = 8'd0;
      byte2_in   = 8'd0;
      date_write = 1'b0;
      y_sel      = 12'd0;
      diff       = 2'd0;
      hour_dec   = from_bcd({2'b00, hour_reg_ff[5:0]});
      day_dec    = from_bcd({2'b00, day_year_reg_ff[5:0]});
      month_dec  = from_bcd({3'b000, month_wd_reg_ff[4:0]});

      case (cmd_ff)
         CMD_LOAD: begin
            second_in  = from_bcd(sec_reg_ff);
            minute_in  = from_bcd(min_reg_ff);
            hour_in    = hour_dec[5:0];
            day_in     = day_dec[5:0];
            month_in   = month_dec[4:0];
            weekday_in = month_wd_reg_ff[7:5];
            y_sel      = (ram_year_ff > {4'd0, year_ceiling_ff}) ? year_floor_ff
                                                                   : ram_year_ff[11:0];
            diff       = day_year_reg_ff[7:6] - y_sel[1:0];
            year_in    = y_sel + {10'd0, diff};
            if (diff != 2'd0) begin
               kind_in = WR_YEAR;
            end
         end
         CMD_ADD_HOUR, CMD_ADD_MINUTE: begin
            if (cmd_ff == CMD_ADD_HOUR) begin
               hour_in = (hour_ff < HOUR_LAST) ? hour_ff + 6'd1 : 6'd0;
            end else begin
               minute_in = (minute_ff < MINUTE_LAST) ? minute_ff + 8'd1 : 8'd0;
            end
            second_in = 8'd0;
            kind_in   = WR_TIME;
            byte0_in  = 8'd0;
            byte1_in  = to_bcd(minute_in);
            byte2_in  = to_bcd({2'b00, hour_in});
         end
         CMD_ADD_YEAR: begin
            y_sel = (year_ff < year_floor_ff) ? year_floor_ff : year_ff;
            year_in    = (y_sel < year_ceiling_ff) ? y_sel + 12'd1 : year_floor_ff;
            date_write = 1'b1;
         end
         CMD_ADD_MONTH: begin
            month_in   = (month_ff < MONTH_LAST) ? month_ff + 5'd1 : 5'd1;
            date_write = 1'b1;
         end
         CMD_ADD_DAY: begin
            day_in     = (day_ff < month_length(month_ff, year_ff[1:0])) ? day_ff + 6'd1 : 6'd1;
            date_write = 1'b1;
         end
         default: ;
      endcase

      if (date_write) begin
         kind_in  = WR_DATE;
         byte0_in = to_bcd({2'b00, day_in}) | {year_in[1:0], 6'd0};
         byte1_in = to_bcd({3'b000, month_in});
         byte2_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         day_ff       <= '0;
         month_ff     <= '0;
         year_ff      <= '0;
         weekday_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            hour_ff    <= hour_in;
            minute_ff  <= minute_in;
            second_ff  <= second_in;
            day_ff     <= day_in;
            month_ff   <= month_in;
            year_ff    <= year_in;
            weekday_ff <= weekday_in;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff  <= kind_in;
         byte0_ff <= byte0_in;
         byte1_ff <= byte1_in;
         byte2_ff <= byte2_in;
      end
   end

   // state only moves when the result register loads, so it is the result
   assign rsp_valid        = out_valid_ff;
   assign rsp_hours        = hour_ff;
   assign rsp_minutes      = minute_ff;
   assign rsp_seconds      = second_ff;
   assign rsp_day_of_month = day_ff;
   assign rsp_month_number = month_ff;
   assign rsp_year_value   = year_ff;
   assign rsp_weekday      = weekday_ff;
   assign rsp_write_kind   = kind_ff;
   assign rsp_write_byte0  = byte0_ff;
   assign rsp_write_byte1  = byte1_ff;
   assign rsp_write_byte2  = byte2_ff;

endmodule

### hdl/rtccs_checker.sv
// Port-level checker for the RTC calendar setting stepper, with its bind.
// Uses rtccs_pkg for the write-kind codes.
`timescale 1ns / 1ps

module rtccs_checker
   import rtccs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_seconds,
   input logic [11:0] rsp_year_value,
   input logic [1:0]  rsp_write_kind,
   input logic [7:0]  rsp_write_byte0,
   input logic [7:0]  rsp_write_byte1,
   input logic [7:0]  rsp_write_byte2
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_time_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_kind == WR_TIME |-> rsp_seconds == 8'd0 && rsp_write_byte0 == 8'd0)
      else $error("time write must clear seconds");

   // day tens digit of 4 shares bit 6 with the year bits
   a_date_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_kind == WR_DATE
         |-> rsp_write_byte2 == 8'd0
             && (rsp_write_byte0[7:6] & rsp_year_value[1:0]) == rsp_year_value[1:0])
      else $error("date bytes inconsistent with year");

   a_no_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_write_kind == WR_NONE || rsp_write_kind == WR_YEAR)
         |-> rsp_write_byte0 == 8'd0 && rsp_write_byte1 == 8'd0 && rsp_write_byte2 == 8'd0)
      else $error("stray write bytes");

endmodule

bind rtc_calendar_setting_stepper rtccs_checker u_rtccs_checker (.*);

### tb/sv/rtc_calendar_setting_stepper_tb.sv
// Testbench for rtc_calendar_setting_stepper: sends load and step transactions,
// predicts the decimal calendar state and write-back bytes, and checks every response.
// Depends on rtccs_pkg and the stepper RTL only.
`timescale 1ns / 1ps

module rtc_calendar_setting_stepper_tb;
   import rtccs_pkg::*;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PRINT_LIMIT   = 40;

   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} stall_style_type;

   typedef struct {
      logic [2:0]  command;
      logic [7:0]  seconds_bcd;
      logic [7:0]  minutes_bcd;
      logic [7:0]  hours_bcd;
      logic [7:0]  day_year;
      logic [7:0]  month_weekday;
      logic [15:0] ram_year;
   } rtc_snapshot_type;

   typedef struct {
      logic [5:0]     hours;
      logic [7:0]     minutes;
      logic [7:0]     seconds;
      logic [5:0]     day;
      logic [4:0]     month;
      logic [11:0]    year;
      logic [2:0]     weekday;
      write_kind_type kind;
      logic [7:0]     byte0;
      logic [7:0]     byte1;
      logic [7:0]     byte2;
   } calendar_view_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [11:0] csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_command;
   logic [7:0]  req_reg_seconds;
   logic [7:0]  req_reg_minutes;
   logic [7:0]  req_reg_hours;
   logic [7:0]  req_reg_day_year;
   logic [7:0]  req_reg_month_weekday;
   logic [15:0] req_ram_year;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_hours;
   logic [7:0]  rsp_minutes;
   logic [7:0]  rsp_seconds;
   logic [5:0]  rsp_day_of_month;
   logic [4:0]  rsp_month_number;
   logic [11:0] rsp_year_value;
   logic [2:0]  rsp_weekday;
   logic [1:0]  rsp_write_kind;
   logic [7:0]  rsp_write_byte0;
   logic [7:0]  rsp_write_byte1;
   logic [7:0]  rsp_write_byte2;

   rtc_calendar_setting_stepper dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_reg_seconds       (req_reg_seconds),
      .req_reg_minutes       (req_reg_minutes),
      .req_reg_hours         (req_reg_hours),
      .req_reg_day_year      (req_reg_day_year),
      .req_reg_month_weekday (req_reg_month_weekday),
      .req_ram_year          (req_ram_year),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_hours             (rsp_hours),
      .rsp_minutes           (rsp_minutes),
      .rsp_seconds           (rsp_seconds),
      .rsp_day_of_month      (rsp_day_of_month),
      .rsp_month_number      (rsp_month_number),
      .rsp_year_value        (rsp_year_value),
      .rsp_weekday           (rsp_weekday),
      .rsp_write_kind        (rsp_write_kind),
      .rsp_write_byte0       (rsp_write_byte0),
      .rsp_write_byte1       (rsp_write_byte1),
      .rsp_write_byte2       (rsp_write_byte2)
   );

   // calendar as the block should hold it
   logic [5:0]  cal_hour    = '0;
   logic [7:0]  cal_minute  = '0;
   logic [7:0]  cal_second  = '0;
   logic [5:0]  cal_day     = '0;
   logic [4:0]  cal_month   = '0;
   logic [11:0] cal_year    = '0;
   logic [2:0]  cal_weekday = '0;
   logic [11:0] floor_limit   = YEAR_FLOOR_RESET;
   logic [11:0] ceiling_limit = YEAR_CEILING_RESET;

   calendar_view_type pending_views[$];
   int                error_count  = 0;
   int                burst_left   = 0;
   bit                request_held = 0;
   int                quiet_cycles = 0;
   int unsigned       cycle_count  = 0;
   stall_style_type   stall_style  = READY_ALWAYS;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] decode_bcd(input logic [7:0] b);
      int v;
      v = b[7:4] * 10 + b[3:0];
      return v[7:0];
   endfunction

   function automatic logic [7:0] encode_bcd(input int unsigned v);
      int unsigned e;
      e = ((v / 10) << 4) | (v % 10);
      return e[7:0];
   endfunction

   function automatic logic [5:0] days_in_month(input logic [4:0] m, input logic [1:0] yl);
      case (m)
         5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: return 6'd31;
         5'd4, 5'd6, 5'd9, 5'd11:                    return 6'd30;
         5'd2:                                        return (yl == 2'd0) ? 6'd29 : 6'd28;
         default:                                     return 6'd0;
      endcase
   endfunction

   function automatic calendar_view_type step_calendar(input rtc_snapshot_type s);
      calendar_view_type v;
      logic [11:0]       y;
      logic [1:0]        shift;
      logic [7:0]        dec;
      bit                date_write;
      v.kind     = WR_NONE;
      v.byte0    = '0;
      v.byte1    = '0;
      v.byte2    = '0;
      date_write = 0;
      case (s.command)
         CMD_LOAD: begin
            cal_second = decode_bcd(s.seconds_bcd);
            cal_minute = decode_bcd(s.minutes_bcd);
            dec        = decode_bcd({2'b00, s.hours_bcd[5:0]});
            cal_hour   = dec[5:0];
            dec        = decode_bcd({2'b00, s.day_year[5:0]});
            cal_day    = dec[5:0];
            if (s.ram_year > {4'd0, ceiling_limit}) y = floor_limit;
            else y = s.ram_year[11:0];
            // raise the year until its low bits agree with the chip's year bits
            shift = s.day_year[7:6] - y[1:0];
            if (shift != 2'd0) begin
               y      = y + {10'd0, shift};
               v.kind = WR_YEAR;
            end
            cal_year    = y;
            dec         = decode_bcd({3'b000, s.month_weekday[4:0]});
            cal_month   = dec[4:0];
            cal_weekday = s.month_weekday[7:5];
         end
         CMD_ADD_HOUR: begin
            cal_hour   = (cal_hour < HOUR_LAST) ? cal_hour + 6'd1 : 6'd0;
            cal_second = '0;
            v.kind     = WR_TIME;
         end
         CMD_ADD_MINUTE: begin
            cal_minute = (cal_minute < MINUTE_LAST) ? cal_minute + 8'd1 : 8'd0;
            cal_second = '0;
            v.kind     = WR_TIME;
         end
         CMD_ADD_YEAR: begin
            if (cal_year < floor_limit) cal_year = floor_limit;
            if (cal_year < ceiling_limit) cal_year = cal_year + 12'd1;
            else cal_year = floor_limit;
            date_write = 1;
         end
         CMD_ADD_MONTH: begin
            cal_month  = (cal_month < MONTH_LAST) ? cal_month + 5'd1 : 5'd1;
            date_write = 1;
         end
         CMD_ADD_DAY: begin
            if (cal_day < days_in_month(cal_month, cal_year[1:0])) cal_day = cal_day + 6'd1;
            else cal_day = 6'd1;
            date_write = 1;
         end
         default: ;
      endcase
      if (v.kind == WR_TIME) begin
         v.byte0 = encode_bcd(cal_second);
         v.byte1 = encode_bcd(cal_minute);
         v.byte2 = encode_bcd(cal_hour);
      end
      if (date_write) begin
         v.kind  = WR_DATE;
         v.byte0 = encode_bcd(cal_day) | {cal_year[1:0], 6'b000000};
         v.byte1 = encode_bcd(cal_month);
      end
      v.hours   = cal_hour;
      v.minutes = cal_minute;
      v.seconds = cal_second;
      v.day     = cal_day;
      v.month   = cal_month;
      v.year    = cal_year;
      v.weekday = cal_weekday;
      return v;
   endfunction

   function automatic rtc_snapshot_type make_snapshot(input logic [2:0] cmd,
         input logic [7:0] sec, input logic [7:0] min, input logic [7:0] hr,
         input logic [7:0] dy, input logic [7:0] mw, input logic [15:0] ry);
      rtc_snapshot_type s;
      s.command       = cmd;
      s.seconds_bcd   = sec;
      s.minutes_bcd   = min;
      s.hours_bcd     = hr;
      s.day_year      = dy;
      s.month_weekday = mw;
      s.ram_year      = ry;
      return s;
   endfunction

   function automatic rtc_snapshot_type random_payload(input logic [2:0] cmd);
      return make_snapshot(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 16'($urandom));
   endfunction

   function automatic rtc_snapshot_type random_snapshot();
      rtc_snapshot_type s;
      int unsigned      pick;
      int               yr;
      pick = $urandom_range(0, 99);
      if (pick < 18) s = random_payload(CMD_LOAD);
      else if (pick < 94) s = random_payload(3'($urandom_range(CMD_ADD_HOUR, CMD_ADD_DAY)));
      else s = random_payload(($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7);
      // most loads look like a real chip snapshot; flag, year and weekday bits stay random
      if (s.command == CMD_LOAD && $urandom_range(0, 3) != 0) begin
         s.seconds_bcd   = encode_bcd($urandom_range(0, 59));
         s.minutes_bcd   = encode_bcd($urandom_range(0, 59));
         s.hours_bcd     = encode_bcd($urandom_range(0, 23)) | (s.hours_bcd & 8'hc0);
         s.day_year      = encode_bcd($urandom_range(1, 31)) | (s.day_year & 8'hc0);
         s.month_weekday = encode_bcd($urandom_range(1, 12)) | (s.month_weekday & 8'he0);
         case ($urandom_range(0, 3))
            0: yr = floor_limit + $urandom_range(0, 8);
            1: yr = ceiling_limit + $urandom_range(0, 6) - 3;
            2: yr = $urandom_range(floor_limit, ceiling_limit);
            default: yr = $urandom;
         endcase
         s.ram_year = yr[15:0];
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
         input logic [15:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
   endtask

   task automatic check_field(input string what, input logic [15:0] got,
         input logic [15:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic release_request();
      if (request_held) begin
         req_valid    <= 1'b0;
         request_held = 0;
      end
   endtask

   task automatic send_snapshot(input rtc_snapshot_type s);
      int gap;
      if (burst_left == 0) begin
         release_request();
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_valid             <= 1'b1;
      req_command           <= s.command;
      req_reg_seconds       <= s.seconds_bcd;
      req_reg_minutes       <= s.minutes_bcd;
      req_reg_hours         <= s.hours_bcd;
      req_reg_day_year      <= s.day_year;
      req_reg_month_weekday <= s.month_weekday;
      req_ram_year          <= s.ram_year;
      request_held = 1;
      do @(posedge clock); while (!req_ready);
      pending_views.push_back(step_calendar(s));
      burst_left--;
   endtask

   task automatic send_step(input logic [2:0] cmd);
      send_snapshot(random_payload(cmd));
   endtask

   task automatic send_load(input logic [7:0] sec, input logic [7:0] min,
         input logic [7:0] hr, input logic [7:0] dy, input logic [7:0] mw,
         input logic [15:0] ry);
      send_snapshot(make_snapshot(CMD_LOAD, sec, min, hr, dy, mw, ry));
   endtask

   task automatic settle_block();
      release_request();
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input logic [11:0] low_year, input logic [11:0] high_year);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_YEAR_FLOOR;
      csr_write_data   <= low_year;
      @(posedge clock);
      floor_limit = low_year;
      csr_index        <= CSR_YEAR_CEILING;
      csr_write_data   <= high_year;
      @(posedge clock);
      ceiling_limit = high_year;
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) send_snapshot(random_snapshot());
   endtask

   // field extremes: all-zero and all-ones registers, spare commands, wraps from
   // out-of-range decoded values
   task automatic test_decode_extremes();
      send_load(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
      send_step(CMD_SPARE_6);
      send_step(CMD_SPARE_7);
      send_load(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff);
      send_step(CMD_ADD_HOUR);
      send_step(CMD_ADD_MINUTE);
      send_step(CMD_ADD_MONTH);
      send_step(CMD_ADD_DAY);
   endtask

   // hour, minute, month and day roll-over, leap and common February
   task automatic test_step_wrap();
      send_load(8'h30, 8'h58, 8'h22, 8'h28, 8'h42, 16'd2024);
      send_step(CMD_ADD_HOUR);
      send_step(CMD_ADD_HOUR);
      send_step(CMD_ADD_MINUTE);
      send_step(CMD_ADD_MINUTE);
      send_step(CMD_ADD_DAY);
      send_step(CMD_ADD_DAY);
      send_load(8'h00, 8'h00, 8'h00, 8'hE8, 8'h02, 16'd2023);
      send_step(CMD_ADD_DAY);
      send_load(8'h00, 8'h00, 8'h80, 8'h15, 8'h11, 16'd2030);
      send_step(CMD_ADD_MONTH);
      send_step(CMD_ADD_MONTH);
   endtask

   // year at the ceiling, above it, below the floor, and chip year bits ahead
   task automatic test_year_match();
      send_load(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 16'd2100);
      send_step(CMD_ADD_YEAR);
      send_load(8'h00, 8'h00, 8'h00, 8'h81, 8'h01, 16'd2101);
      send_load(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 16'd100);
      send_step(CMD_ADD_YEAR);
   endtask

   task automatic test_limit_settings();
      write_limits(12'd0, 12'd0);
      send_load(8'h00, 8'h00, 8'h00, 8'h41, 8'h01, 16'd0);
      send_step(CMD_ADD_YEAR);
      run_random(30);
      // floor above ceiling
      write_limits(12'd4095, 12'd0);
      send_load(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 16'd5);
      send_step(CMD_ADD_YEAR);
      run_random(30);
      write_limits(12'd0, 12'd4095);
      send_load(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 16'd4095);
      send_step(CMD_ADD_YEAR);
      send_load(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 16'hffff);
      run_random(30);
      write_limits(12'd4095, 12'd4095);
      send_load(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 16'd4094);
      send_step(CMD_ADD_YEAR);
      run_random(30);
      write_limits(YEAR_FLOOR_RESET, YEAR_CEILING_RESET);
      run_random(30);
   endtask

   task automatic test_random_sessions();
      int low_year;
      int high_year;
      for (int i = 0; i < 5; i++) begin
         run_random(270);
         low_year = $urandom_range(0, 4000);
         if ($urandom_range(0, 4) == 0) high_year = $urandom_range(0, low_year);
         else high_year = $urandom_range(low_year, 4095);
         write_limits(12'(low_year), 12'(high_year));
      end
   endtask

   always @(posedge clock) begin : drive_rsp_ready
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 0) stall_style <= stall_style_type'($urandom_range(0, 2));
      case (stall_style)
         READY_ALWAYS:  rsp_ready <= 1'b1;
         READY_RANDOM:  rsp_ready <= ($urandom_range(0, 2) != 0);
         default:       rsp_ready <= (cycle_count % 6) >= 2;
      endcase
   end

   always @(posedge clock) begin : check_responses
      calendar_view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_views.size() == 0) begin
            report_mismatch("transaction with nothing pending", 16'h0, 16'h0);
         end else begin
            want = pending_views.pop_front();
            check_field("hours", 16'(rsp_hours), 16'(want.hours));
            check_field("minutes", 16'(rsp_minutes), 16'(want.minutes));
            check_field("seconds", 16'(rsp_seconds), 16'(want.seconds));
            check_field("day_of_month", 16'(rsp_day_of_month), 16'(want.day));
            check_field("month_number", 16'(rsp_month_number), 16'(want.month));
            check_field("year_value", 16'(rsp_year_value), 16'(want.year));
            check_field("weekday", 16'(rsp_weekday), 16'(want.weekday));
            check_field("write_kind", 16'(rsp_write_kind), 16'(want.kind));
            check_field("write_byte0", 16'(rsp_write_byte0), 16'(want.byte0));
            check_field("write_byte1", 16'(rsp_write_byte1), 16'(want.byte1));
            check_field("write_byte2", 16'(rsp_write_byte2), 16'(want.byte2));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_tests
      reset                 <= 1'b1;
      csr_write_enable      <= 1'b0;
      csr_index             <= CSR_YEAR_FLOOR;
      csr_write_data        <= '0;
      req_valid             <= 1'b0;
      req_command           <= CMD_LOAD;
      req_reg_seconds       <= '0;
      req_reg_minutes       <= '0;
      req_reg_hours         <= '0;
      req_reg_day_year      <= '0;
      req_reg_month_weekday <= '0;
      req_ram_year          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_decode_extremes();
      test_step_wrap();
      test_year_match();
      test_limit_settings();
      test_random_sessions();
      settle_block();
      if (error_count == 0 && pending_views.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### rtc_calendar_setting_stepper.f
hdl/rtccs_pkg.sv
hdl/rtc_calendar_setting_stepper.sv
hdl/rtccs_checker.sv
tb/sv/rtc_calendar_setting_stepper_tb.sv
